@@ rtl/touch_key_event_detector_core_macros.svh @@
// ---------------------------------------------------------------------------
// touch_key_event_detector_core_macros
// Assertion helpers shared by the key event detector RTL.
// ---------------------------------------------------------------------------
`ifndef TOUCH_KEY_EVENT_DETECTOR_CORE_MACROS_SVH
`define TOUCH_KEY_EVENT_DETECTOR_CORE_MACROS_SVH

// Combinational check, sampled at every clock edge outside reset.
`define TKED_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define TKED_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tked_pkg.sv @@
// ---------------------------------------------------------------------------
// tked_pkg
// Types, constants and helpers for the touch key event detector.
// ---------------------------------------------------------------------------
`default_nettype none

package tked_pkg;

   // Build-time geometry
   localparam int NUM_KEYS     = 12;
   localparam int TIME_BITS    = 32;
   localparam int MASK_BITS    = 12;
   localparam int SCAN_KEYS    = (NUM_KEYS < MASK_BITS) ? NUM_KEYS : MASK_BITS;
   localparam int KEY_IDX_BITS = 4;
   localparam int KEY_BITS     = 5;
   localparam int COUNT_BITS   = 8;
   localparam int CFG_TIME_BITS = 16;
   localparam int CSR_IDX_BITS  = 2;

   typedef logic [TIME_BITS-1:0]     time_type;
   typedef logic [KEY_IDX_BITS-1:0]  key_idx_type;
   typedef logic [KEY_BITS-1:0]      key_type;
   typedef logic [COUNT_BITS-1:0]    count_type;
   typedef logic [MASK_BITS-1:0]     mask_type;
   typedef logic [CFG_TIME_BITS-1:0] cfg_time_type;

   localparam key_type   KEY_NONE  = key_type'(16);
   localparam count_type COUNT_MAX = '1;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MULTI_CLICK = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLD_TIME   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REPEAT_WIN  = 2'd2;

   localparam cfg_time_type HOLD_TIME_RESET  = cfg_time_type'(600);
   localparam cfg_time_type REPEAT_WIN_RESET = cfg_time_type'(400);

   typedef enum logic [1:0] {
      ST_IDLE     = 2'd0,
      ST_PRESSED  = 2'd1,
      ST_HOLDING  = 2'd2,
      ST_RELEASED = 2'd3
   } state_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESSED = 2'd1,
      EV_HOLD    = 2'd2,
      EV_IDLE    = 2'd3
   } event_type;

   typedef struct packed {
      logic         multi_click;
      cfg_time_type hold_time;
      cfg_time_type repeat_win;
   } cfg_type;

   typedef struct packed {
      mask_type touch_mask;
      time_type now;
   } poll_type;

   typedef struct packed {
      event_type   event_res;
      key_idx_type key_index;
      logic        key_valid;
      count_type   click_count;
   } result_type;

   // Highest touched electrode; 0 when nothing is touched.
   function automatic key_idx_type top_key(input mask_type mask);
      key_idx_type k;
      k = '0;
      for (int i = 0; i < SCAN_KEYS; i++) begin
         if (mask[i]) begin
            k = key_idx_type'(i);
         end
      end
      return k;
   endfunction

endpackage

`default_nettype wire

@@ rtl/tked_csr_regs.sv @@
// ---------------------------------------------------------------------------
// tked_csr_regs
// Configuration register file; always ready, unknown indexes dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module tked_csr_regs (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   input  wire logic [tked_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [tked_pkg::CFG_TIME_BITS-1:0] csr_data,
   output      logic                              csr_ready,
   output      tked_pkg::cfg_type                 cfg
);

   tked_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tked_pkg::CSR_MULTI_CLICK: cfg_in.multi_click = csr_data[0];
            tked_pkg::CSR_HOLD_TIME:   cfg_in.hold_time   = csr_data;
            tked_pkg::CSR_REPEAT_WIN:  cfg_in.repeat_win  = csr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.multi_click <= 1'b0;
         cfg_ff.hold_time   <= tked_pkg::HOLD_TIME_RESET;
         cfg_ff.repeat_win  <= tked_pkg::REPEAT_WIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/tked_event_core.sv @@
// ---------------------------------------------------------------------------
// tked_event_core
// Key FSM and result register; one registered poll a cycle unless rsp stalls.
// ---------------------------------------------------------------------------
`default_nettype none
`include "touch_key_event_detector_core_macros.svh"

module tked_event_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tked_pkg::cfg_type    cfg,
   input  wire logic                 poll_valid,
   input  wire tked_pkg::poll_type   poll,
   output      logic                 poll_take,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      tked_pkg::result_type rsp
);

   tked_pkg::state_type  state_ff, state_in;
   tked_pkg::time_type   entry_ff, entry_in;
   tked_pkg::key_type    cur_key_ff, cur_key_in;
   tked_pkg::key_type    ear_key_ff, ear_key_in;
   tked_pkg::count_type  count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tked_pkg::result_type rsp_ff, rsp_in;

   logic                  touched;
   tked_pkg::key_idx_type key;
   tked_pkg::key_type     key_w;
   tked_pkg::time_type    elapsed;
   tked_pkg::count_type   count_sat;
   logic                  hold_over, win_over, go_idle;
   tked_pkg::event_type   ev;
   tked_pkg::count_type   count_out;

   assign poll_take = poll_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign touched   = (poll.touch_mask[tked_pkg::SCAN_KEYS-1:0] != '0);
   assign key       = tked_pkg::top_key(poll.touch_mask);
   assign key_w     = touched ? {1'b0, key} : cur_key_ff;
   assign elapsed   = poll.now - entry_ff;
   assign count_sat = (count_ff == tked_pkg::COUNT_MAX) ? count_ff
                                                         : count_ff + 1'b1;
   assign hold_over = elapsed > tked_pkg::time_type'(cfg.hold_time);
   assign win_over  = elapsed > tked_pkg::time_type'(cfg.repeat_win);

   always_comb begin
      state_in   = state_ff;
      entry_in   = entry_ff;
      cur_key_in = key_w;
      ear_key_in = ear_key_ff;
      count_in   = count_ff;
      ev         = tked_pkg::EV_NONE;
      count_out  = count_ff;
      go_idle    = 1'b0;

      case (state_ff)
         tked_pkg::ST_IDLE: begin
            if (touched) begin
               count_in  = count_sat;
               count_out = count_sat;
               state_in  = tked_pkg::ST_PRESSED;
               entry_in  = poll.now;
               if (cfg.multi_click) begin
                  ev = tked_pkg::EV_PRESSED;
               end
            end
         end
         tked_pkg::ST_PRESSED: begin
            if (!touched) begin
               if (!cfg.multi_click) begin
                  go_idle = 1'b1;
                  ev      = tked_pkg::EV_PRESSED;
               end else begin
                  state_in   = tked_pkg::ST_RELEASED;
                  entry_in   = poll.now;
                  ear_key_in = key_w;
               end
            end else if (!cfg.multi_click && hold_over) begin
               state_in = tked_pkg::ST_HOLDING;
               entry_in = poll.now;
               ev       = tked_pkg::EV_HOLD;
            end
         end
         tked_pkg::ST_HOLDING: begin
            if (!touched) begin
               go_idle = 1'b1;
            end
         end
         tked_pkg::ST_RELEASED: begin
            // window timeout wins over a re-press
            if (win_over) begin
               go_idle = 1'b1;
               ev      = tked_pkg::EV_IDLE;
            end else if (touched) begin
               if (key_w == ear_key_ff) begin
                  state_in  = tked_pkg::ST_PRESSED;
                  entry_in  = poll.now;
                  count_in  = count_sat;
                  count_out = count_sat;
                  ev        = tked_pkg::EV_PRESSED;
               end else begin
                  go_idle = 1'b1;
               end
            end
         end
         default: begin
            go_idle = 1'b1;
         end
      endcase

      if (go_idle) begin
         state_in   = tked_pkg::ST_IDLE;
         entry_in   = poll.now;
         cur_key_in = tked_pkg::KEY_NONE;
         ear_key_in = tked_pkg::KEY_NONE;
         count_in   = '0;
      end

      rsp_in.event_res   = ev;
      rsp_in.key_index   = key;
      rsp_in.key_valid   = touched;
      rsp_in.click_count = count_out;

      rsp_valid_in = poll_take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tked_pkg::ST_IDLE;
         entry_ff     <= '0;
         cur_key_ff   <= tked_pkg::KEY_NONE;
         ear_key_ff   <= tked_pkg::KEY_NONE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (poll_take) begin
            state_ff   <= state_in;
            entry_ff   <= entry_in;
            cur_key_ff <= cur_key_in;
            ear_key_ff <= ear_key_in;
            count_ff   <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (poll_take) begin
         rsp_ff <= rsp_in;
      end
   end

   // idle always carries cleared key tracking and count
   `TKED_ASSERT(a_idle_clear, clock, reset,
      (state_ff != tked_pkg::ST_IDLE) || (count_ff == '0 &&
       cur_key_ff == tked_pkg::KEY_NONE && ear_key_ff == tked_pkg::KEY_NONE),
      "idle state with stale key or count")
   // pressed is only reached through a counted press
   `TKED_ASSERT(a_pressed_counted, clock, reset,
      (state_ff != tked_pkg::ST_PRESSED) || (count_ff != '0),
      "pressed state with zero count")
   // a pending hold result matches the holding state it entered
   `TKED_ASSERT(a_hold_state, clock, reset,
      !(rsp_valid_ff && rsp_ff.event_res == tked_pkg::EV_HOLD) ||
      (state_ff == tked_pkg::ST_HOLDING),
      "hold result without holding state")
   // a taken poll always shows up as a result
   `TKED_ASSERT_NEXT(a_take_result, clock, reset, poll_take, rsp_valid_ff,
      "taken poll produced no result")

endmodule

`default_nettype wire

@@ rtl/touch_key_event_detector_core.sv @@
// ---------------------------------------------------------------------------
// touch_key_event_detector_core
// Press, hold and multi-click detector for a polled touch keypad.
// ---------------------------------------------------------------------------
// Each req beat is one poll: an electrode touch mask and a millisecond
// timestamp. Each poll gives exactly one rsp beat with the event (none,
// pressed, hold, idle after the repeat window), the highest touched key,
// a touch flag and the click count. Throughput is one poll per clock while
// rsp is not stalled; the poll goes through an input register and then a
// result register. The per-poll work (priority encode, one 32-bit subtract
// and two compares, state update) is a single combinational pass between
// those registers.
// req_tready drops only while both registers are full and rsp is stalled.
// Configuration writes are always accepted (csr_ready tied high) and are
// meant to happen between polls; unknown register indexes are ignored.
// ---------------------------------------------------------------------------
`default_nettype none

module touch_key_event_detector_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // poll channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [47:0] req_tdata,   // [11:0] touch_mask, [43:12] time_ms, rest zero
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // [1:0] event_res, [5:2] key_index,
                                         // [6] key_valid, [14:7] click_count, [15] zero
   // configuration write
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   tked_pkg::cfg_type    cfg;
   tked_pkg::poll_type   poll_ff, poll_in;
   logic                 poll_valid_ff, poll_valid_in;
   logic                 poll_take;
   logic                 rsp_valid;
   tked_pkg::result_type rsp;
   logic                 req_beat;

   tked_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   // Input register: refills in the same cycle the core takes its poll.
   assign req_tready = !poll_valid_ff || poll_take;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      poll_in.touch_mask = req_tdata[11:0];
      // only the low TIME_BITS of the timestamp take part
      poll_in.now        = req_tdata[12 +: tked_pkg::TIME_BITS];
      poll_valid_in      = req_beat || (poll_valid_ff && !poll_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
      end else begin
         poll_valid_ff <= poll_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         poll_ff <= poll_in;
      end
   end

   tked_event_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .poll_valid (poll_valid_ff),
      .poll       (poll_ff),
      .poll_take  (poll_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // Result beat packing, first field lowest.
   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {1'b0, rsp.click_count, rsp.key_valid, rsp.key_index,
                        rsp.event_res};

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ============================================================================
// tb_top
// Self-checking bench for the touch key event detector core.
// Polls go in on the req stream and one result beat per poll comes back on
// the rsp stream. A behavioral model of the press/hold/multi-click machine
// kept in the bench predicts every result, and the results are compared field
// by field in order. A short directed table covers reset, the hold and window
// edges, timestamp wrap and the register write path. Random phases under
// several register settings follow, then a long multi-click burst that drives
// the click count into saturation. Both streams idle and stall at random.
// ============================================================================
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned PHASE_POLLS = 14;
   localparam int unsigned BURST_PRESSES = 258;
   // index with no register behind it; writes must be dropped
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // ---------------------------------------------------------------------
   // DUT hookup
   // ---------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // [11:0] touch_mask, [43:12] time_ms, [47:44] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [1:0] event_res, [5:2] key_index, [6] key_valid,
                             // [14:7] click_count, [15] zero
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   touch_key_event_detector_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Key machine model: registers and state as the block should hold them
   // ---------------------------------------------------------------------
   logic                   multi_on  = 1'b0;
   tked_pkg::cfg_time_type hold_ms   = tked_pkg::HOLD_TIME_RESET;
   tked_pkg::cfg_time_type window_ms = tked_pkg::REPEAT_WIN_RESET;

   tked_pkg::state_type    fsm_state  = tked_pkg::ST_IDLE;
   tked_pkg::time_type     entered_ms = '0;
   tked_pkg::key_type      cur_key    = tked_pkg::KEY_NONE;
   tked_pkg::key_type      prev_key   = tked_pkg::KEY_NONE;
   tked_pkg::count_type    presses    = '0;

   tked_pkg::result_type   pending_results[$];   // predicted rsp beats, oldest first
   int unsigned            mismatches = 0;
   int unsigned            cycle_count = 0;
   bit                     quiet = 1'b0;         // no gaps or stalls while set
   int unsigned            stall_left = 0;
   tked_pkg::time_type     last_ms = '0;
   int unsigned            gest_key = 0;

   function automatic void move_to(input tked_pkg::state_type nxt,
                                   input tked_pkg::time_type now);
      fsm_state  = nxt;
      entered_ms = now;
      if (nxt == tked_pkg::ST_IDLE) begin
         cur_key  = tked_pkg::KEY_NONE;
         prev_key = tked_pkg::KEY_NONE;
         presses  = '0;
      end
   endfunction

   function automatic void bump_presses();
      if (presses != tked_pkg::COUNT_MAX) begin
         presses = presses + 1'b1;
      end
   endfunction

   // One poll through the machine; returns the rsp beat it should give.
   function automatic tked_pkg::result_type predict_poll(input tked_pkg::mask_type mask,
                                                         input tked_pkg::time_type now);
      tked_pkg::mask_type    live;
      tked_pkg::time_type    elapsed;
      logic                  touched;
      tked_pkg::key_idx_type key;
      bit                    found;
      tked_pkg::event_type   ev;
      tked_pkg::count_type   cnt;
      tked_pkg::result_type  res;
      live    = mask & tked_pkg::mask_type'((1 << tked_pkg::NUM_KEYS) - 1);
      elapsed = now - entered_ms;
      touched = |live;
      key     = '0;
      found   = 1'b0;
      ev      = tked_pkg::EV_NONE;
      for (int i = tked_pkg::NUM_KEYS - 1; i >= 0; i--) begin
         if (live[i] && !found) begin
            key   = tked_pkg::key_idx_type'(i);
            found = 1'b1;
         end
      end
      if (touched) begin
         cur_key = tked_pkg::key_type'(key);
      end
      cnt = presses;
      case (fsm_state)
         tked_pkg::ST_IDLE: begin
            if (touched) begin
               bump_presses();
               cnt = presses;
               move_to(tked_pkg::ST_PRESSED, now);
               if (multi_on) ev = tked_pkg::EV_PRESSED;
            end
         end
         tked_pkg::ST_PRESSED: begin
            if (!touched) begin
               if (!multi_on) begin
                  move_to(tked_pkg::ST_IDLE, now);
                  ev = tked_pkg::EV_PRESSED;
               end else begin
                  move_to(tked_pkg::ST_RELEASED, now);
                  prev_key = cur_key;
               end
            end else if (!multi_on && elapsed > tked_pkg::time_type'(hold_ms)) begin
               move_to(tked_pkg::ST_HOLDING, now);
               ev = tked_pkg::EV_HOLD;
            end
         end
         tked_pkg::ST_HOLDING: begin
            if (!touched) move_to(tked_pkg::ST_IDLE, now);
         end
         default: begin
            // window timeout wins over any touch
            if (elapsed > tked_pkg::time_type'(window_ms)) begin
               move_to(tked_pkg::ST_IDLE, now);
               ev = tked_pkg::EV_IDLE;
            end else if (touched) begin
               if (cur_key == prev_key) begin
                  move_to(tked_pkg::ST_PRESSED, now);
                  bump_presses();
                  cnt = presses;
                  ev = tked_pkg::EV_PRESSED;
               end else begin
                  move_to(tked_pkg::ST_IDLE, now);
               end
            end
         end
      endcase
      res.event_res   = ev;
      res.key_index   = touched ? key : tked_pkg::key_idx_type'(0);
      res.key_valid   = touched;
      res.click_count = cnt;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Mostly the current gesture key (with random lower electrodes), else
   // releases, stray keys, full masks and the single-electrode extremes.
   function automatic tked_pkg::mask_type pick_mask();
      int unsigned        r;
      tked_pkg::mask_type hi;
      r  = $urandom_range(0, 19);
      hi = tked_pkg::mask_type'(1) << gest_key;
      if (r < 9)  return hi | (tked_pkg::mask_type'($urandom) & (hi - 1'b1));
      if (r < 15) return '0;
      if (r == 15) return tked_pkg::mask_type'($urandom_range(0, 4095));
      if (r == 16) return tked_pkg::mask_type'(1) << $urandom_range(0, tked_pkg::NUM_KEYS - 1);
      if (r == 17) return '1;
      if (r == 18) return tked_pkg::mask_type'(1);
      return tked_pkg::mask_type'(1) << (tked_pkg::NUM_KEYS - 1);
   endfunction

   // Timestamps aimed at the live threshold (hold or window) of the model,
   // plus steady ticks, big jumps, backward steps and wrap.
   function automatic tked_pkg::time_type pick_time();
      int unsigned        r;
      tked_pkg::time_type thr;
      tked_pkg::time_type t;
      r = $urandom_range(0, 19);
      if (fsm_state == tked_pkg::ST_PRESSED)       thr = tked_pkg::time_type'(hold_ms);
      else if (fsm_state == tked_pkg::ST_RELEASED) thr = tked_pkg::time_type'(window_ms);
      else                                         thr = tked_pkg::time_type'(50);
      if (r < 8)       t = last_ms + $urandom_range(0, 40);
      else if (r < 12) t = entered_ms + thr + 1 - $urandom_range(0, 2);
      else if (r < 15) t = entered_ms + $urandom_range(0, 2 * thr + 2);
      else if (r < 17) t = last_ms + $urandom_range(100, 2000);
      else if (r == 17) t = tked_pkg::time_type'($urandom);
      else if (r == 18) t = entered_ms - $urandom_range(1, 3);
      else             t = '1 - $urandom_range(0, 20);
      last_ms = t;
      return t;
   endfunction

   // One poll beat; valid stays up after the handshake so back-to-back
   // polls need no dead cycle.
   task automatic send_poll(input tked_pkg::mask_type mask, input tked_pkg::time_type now,
                            input bit typed, input tked_pkg::result_type want);
      int unsigned          gap;
      tked_pkg::result_type res;
      gap = pick_gap();
      res = predict_poll(mask, now);
      pending_results.push_back(typed ? want : res);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, now, mask};
      do @(posedge clock); while (!req_tready);
   endtask

   // Register write, only once every poll in flight has come back.
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         tked_pkg::CSR_MULTI_CLICK: multi_on  = val[0];
         tked_pkg::CSR_HOLD_TIME:   hold_ms   = val;
         tked_pkg::CSR_REPEAT_WIN:  window_ms = val;
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------
   typedef struct {
      bit                   is_csr;
      logic [1:0]           idx;
      logic [15:0]          data;
      tked_pkg::mask_type   mask;
      tked_pkg::time_type   ms;
      bit                   typed;
      tked_pkg::result_type want;
   } step_row_type;

   function automatic step_row_type poll_row(input tked_pkg::mask_type m,
                                             input tked_pkg::time_type t);
      return '{1'b0, 2'd0, 16'd0, m, t, 1'b0, '0};
   endfunction

   function automatic step_row_type poll_chk(input tked_pkg::mask_type m,
                                             input tked_pkg::time_type t,
                                             input tked_pkg::event_type ev,
                                             input tked_pkg::key_idx_type k,
                                             input logic v, input tked_pkg::count_type c);
      tked_pkg::result_type w;
      w.event_res   = ev;
      w.key_index   = k;
      w.key_valid   = v;
      w.click_count = c;
      return '{1'b0, 2'd0, 16'd0, m, t, 1'b1, w};
   endfunction

   function automatic step_row_type csr_row(input logic [1:0] i, input logic [15:0] d);
      return '{1'b1, i, d, '0, '0, 1'b0, '0};
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      tked_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: rsp beat with nothing expected, actual %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("event_res",   want.event_res,   rsp_tdata[1:0]);
            check_field("key_index",   want.key_index,   rsp_tdata[5:2]);
            check_field("key_valid",   want.key_valid,   rsp_tdata[6]);
            check_field("click_count", want.click_count, rsp_tdata[14:7]);
         end
      end
   end

   // rsp back-pressure: mostly ready, short stalls, now and then a long one
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      step_row_type       rows[$];
      step_row_type       row;
      logic               p_mode;
      logic [15:0]        p_hold;
      logic [15:0]        p_win;
      tked_pkg::time_type t;

      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;

      // After reset: single click, hold 600, window 400.
      rows.push_back(poll_chk(12'h000, 32'd0, tked_pkg::EV_NONE, 4'd0, 1'b0, 8'd0));
      rows.push_back(poll_row(12'hFFF, 32'd100));
      // exactly at the hold time is not yet a hold
      rows.push_back(poll_chk(12'h800, 32'd700, tked_pkg::EV_NONE, 4'd11, 1'b1, 8'd1));
      rows.push_back(poll_chk(12'h801, 32'd701, tked_pkg::EV_HOLD, 4'd11, 1'b1, 8'd1));
      rows.push_back(poll_row(12'h000, 32'd800));          // holding -> idle, quiet
      rows.push_back(poll_row(12'h001, 32'd900));
      // quick tap: press reported on release
      rows.push_back(poll_chk(12'h000, 32'd950, tked_pkg::EV_PRESSED, 4'd0, 1'b0, 8'd1));
      rows.push_back(csr_row(tked_pkg::CSR_MULTI_CLICK, 16'h0001));
      rows.push_back(poll_chk(12'h010, 32'd1000, tked_pkg::EV_PRESSED, 4'd4, 1'b1, 8'd1));
      rows.push_back(poll_row(12'h000, 32'd1010));
      rows.push_back(poll_row(12'h01F, 32'd1410));         // same key at window edge
      rows.push_back(poll_row(12'h000, 32'd1420));
      rows.push_back(poll_row(12'h020, 32'd1500));         // other key drops to idle
      rows.push_back(poll_row(12'h004, 32'd1600));
      rows.push_back(poll_row(12'h000, 32'd1700));
      // window timeout beats the touch
      rows.push_back(poll_chk(12'h004, 32'd2101, tked_pkg::EV_IDLE, 4'd2, 1'b1, 8'd1));
      rows.push_back(csr_row(tked_pkg::CSR_REPEAT_WIN, 16'hFFFF));
      // timestamp wrap: re-press lands exactly on the widest window
      rows.push_back(poll_row(12'h400, 32'hFFFF_FFF0));
      rows.push_back(poll_row(12'h000, 32'h0000_0005));
      rows.push_back(poll_chk(12'h400, 32'h0001_0004, tked_pkg::EV_PRESSED, 4'd10, 1'b1,
                              8'd2));
      rows.push_back(poll_row(12'h000, 32'h0001_0005));
      // step back in time wraps the elapsed count to its top
      rows.push_back(poll_chk(12'h000, 32'h0001_0004, tked_pkg::EV_IDLE, 4'd0, 1'b0, 8'd2));
      rows.push_back(csr_row(CSR_SPARE, 16'hFFFF));
      rows.push_back(csr_row(tked_pkg::CSR_MULTI_CLICK, 16'hFFFE)); // only bit 0 counts
      rows.push_back(csr_row(tked_pkg::CSR_HOLD_TIME, 16'h0000));
      rows.push_back(poll_row(12'h002, 32'h0001_0010));
      rows.push_back(poll_chk(12'h002, 32'h0001_0010, tked_pkg::EV_NONE, 4'd1, 1'b1, 8'd1));
      rows.push_back(poll_chk(12'h003, 32'h0001_0011, tked_pkg::EV_HOLD, 4'd1, 1'b1, 8'd1));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         row = rows[i];
         if (row.is_csr) begin
            write_csr(row.idx, row.data);
         end else begin
            send_poll(row.mask, row.ms, row.typed, row.want);
         end
      end
      last_ms = 32'h0001_0011;

      // Random phases under a spread of register settings.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin p_mode = 1'b0; p_hold = 16'd600;   p_win = 16'd400;   end
            1: begin p_mode = 1'b1; p_hold = 16'd600;   p_win = 16'd400;   end
            2: begin p_mode = 1'b0; p_hold = 16'd0;     p_win = 16'd0;     end
            3: begin p_mode = 1'b1; p_hold = 16'hFFFF;  p_win = 16'hFFFF;  end
            4: begin p_mode = 1'b1; p_hold = 16'd0;     p_win = 16'd0;     end
            5: begin p_mode = 1'b0; p_hold = 16'hFFFF;  p_win = 16'hFFFF;  end
            6: begin
               p_mode = 1'($urandom_range(0, 1));
               p_hold = 16'($urandom_range(0, 1000));
               p_win  = 16'($urandom_range(0, 1000));
            end
            default: begin
               p_mode = 1'($urandom_range(0, 1));
               p_hold = 16'($urandom);
               p_win  = 16'($urandom);
            end
         endcase
         write_csr(tked_pkg::CSR_MULTI_CLICK, {15'($urandom), p_mode});
         write_csr(tked_pkg::CSR_HOLD_TIME, p_hold);
         write_csr(tked_pkg::CSR_REPEAT_WIN, p_win);
         quiet = (ph == 3 || ph == 6);
         for (int n = 0; n < PHASE_POLLS; n++) begin
            if (fsm_state == tked_pkg::ST_IDLE && $urandom_range(0, 2) == 0) begin
               gest_key = $urandom_range(0, tked_pkg::NUM_KEYS - 1);
            end
            t = pick_time();
            send_poll(pick_mask(), t, 1'b0, '0);
         end
      end

      // Long multi-click burst on one key: drives the count into saturation.
      quiet = 1'b0;
      write_csr(tked_pkg::CSR_MULTI_CLICK, 16'h0001);
      write_csr(tked_pkg::CSR_REPEAT_WIN, 16'hFFFF);
      t = last_ms;
      for (int n = 0; n < BURST_PRESSES; n++) begin
         t = t + $urandom_range(1, 50);
         send_poll(12'h080 | tked_pkg::mask_type'($urandom_range(0, 127)), t, 1'b0, '0);
         t = t + $urandom_range(1, 50);
         send_poll(12'h000, t, 1'b0, '0);
      end
      // saturated count survives one more press, then the window expires
      send_poll(12'h080, t + 32'd10, 1'b0, '0);
      send_poll(12'h000, t + 32'd20, 1'b0, '0);
      send_poll(12'h000, t + 32'd70000, 1'b0, '0);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
